// ===== src/insertion_sorter_defines.svh =====
// Assertion macros shared by the insertion sorter checkers.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Concurrent check on the rising clock edge, quiet while reset is high.
`define ISORT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define ISORT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/isort_pkg.sv =====
// Shared constants and types for the insertion sorter cell chain.
package isort_pkg;

   // Number of cells in the chain, at least 2 and at most 64.
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   // The operation that every cell carries out.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT
   } cell_op_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type                   op;
      logic signed [DATA_WIDTH-1:0]  value;
   } cell_cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic                          occupied;
      logic                          greater;
      logic signed [DATA_WIDTH-1:0]  value;
   } cell_link_type;

endpackage

// ===== src/isort_cell.sv =====
// One cell of the sorting chain: holds a single value and its occupied bit.
module isort_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  isort_pkg::cell_cmd_type  cmd,
   input  isort_pkg::cell_link_type left_link,
   input  isort_pkg::cell_link_type right_link,
   output isort_pkg::cell_link_type own_link
);
   import isort_pkg::*;

   logic                         occupied_ff, occupied_in;
   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic                         greater;
   logic signed [DATA_WIDTH-1:0] insert_value;

   // Strictly greater, so a new value lands after its equals
   assign greater = occupied_ff && (value_ff > cmd.value);

   // Value moving in from the left on insertion: the neighbor's if it is moving, else the new one
   assign insert_value = left_link.greater ? left_link.value : cmd.value;

   // Next state
   always_comb begin
      occupied_in = occupied_ff;
      value_in    = value_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (greater) begin
               value_in = insert_value;
            end else if (!occupied_ff && left_link.occupied) begin
               // first free cell
               value_in    = insert_value;
               occupied_in = 1'b1;
            end
         end
         OP_SHIFT: begin
            value_in    = right_link.value;
            occupied_in = right_link.occupied;
         end
         OP_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
      value_ff <= value_in;
   end

   assign own_link.occupied = occupied_ff;
   assign own_link.greater  = greater;
   assign own_link.value    = value_ff;

endmodule

// ===== src/insertion_sorter.sv =====
// Insertion sorter: a chain of cells that keeps signed values in ascending order.
//
// Values are sent one per request: busy stays low, so a new value can follow
// every cycle outside a flush. All cells compare against the new value at once
// and the larger ones step one place right, opening the slot. Once the chain
// holds CAPACITY values further values are dropped and rsp_overflowed is
// reported on the next flush. A request with req_end_mark set flushes the
// chain: busy goes high and the chain shifts left one cell per cycle until it
// is empty; the results come out on rsp_valid one per cycle in ascending
// order, the first one once the flush state and then the head value have been
// registered, the largest flagged by rsp_last_of_run. The receiver cannot
// stall, so results must be taken as they appear. An empty flush gives no
// results.
module insertion_sorter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [isort_pkg::DATA_WIDTH-1:0] req_data_value,
   input  logic                                   req_end_mark,
   output logic                                   busy,
   output logic                                   rsp_valid,
   output logic signed [isort_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                                   rsp_last_of_run,
   output logic                                   rsp_overflowed
);
   import isort_pkg::*;

   cell_link_type links [CAPACITY];
   cell_cmd_type  cmd;

   logic flushing_ff, flushing_in;
   logic dropped_ff, dropped_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_overflowed_ff, rsp_overflowed_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic accept;
   logic full;

   assign accept = start && !flushing_ff;
   assign full   = links[CAPACITY-1].occupied;

   // Controller: decide the chain operation and the result
   always_comb begin
      cmd.op            = OP_HOLD;
      cmd.value         = req_data_value;
      flushing_in       = flushing_ff;
      dropped_in        = dropped_ff;
      rsp_valid_in      = 1'b0;
      rsp_value_in      = links[0].value;
      rsp_last_in       = !links[1].occupied;
      rsp_overflowed_in = dropped_ff;
      if (flushing_ff) begin
         if (links[0].occupied) begin
            cmd.op       = OP_SHIFT;
            rsp_valid_in = 1'b1;
         end else begin
            // chain drained
            flushing_in = 1'b0;
            dropped_in  = 1'b0;
         end
      end else if (accept) begin
         if (req_end_mark) begin
            flushing_in = 1'b1;
         end else if (full) begin
            dropped_in = 1'b1;
         end else begin
            cmd.op = OP_INSERT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flushing_ff  <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flushing_ff  <= flushing_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff      <= rsp_value_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_overflowed_ff <= rsp_overflowed_in;
   end

   // The chain; the head sees an occupied, never-greater left neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_side;
      cell_link_type right_side;
      if (i == 0) begin : g_head
         assign left_side.occupied = 1'b1;
         assign left_side.greater  = 1'b0;
         assign left_side.value    = '0;
      end else begin : g_body
         assign left_side = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_side = '0;
      end else begin : g_inner
         assign right_side = links[i+1];
      end
      isort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (left_side),
         .right_link (right_side),
         .own_link   (links[i])
      );
   end

   assign busy             = flushing_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_overflowed   = rsp_overflowed_ff;

endmodule

// ===== src/isort_checker.sv =====
// Port-level checks for the insertion sorter, bound to the top level.
`include "insertion_sorter_defines.svh"

module isort_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic signed [isort_pkg::DATA_WIDTH-1:0] req_data_value,
   input logic                                   req_end_mark,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic signed [isort_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   input logic                                   rsp_last_of_run,
   input logic                                   rsp_overflowed
);
   import isort_pkg::*;

   // A result only comes out of a flush
   `ISORT_ASSERT(a_rsp_in_flush, rsp_valid |-> $past(busy), "result outside a flush")

   // A flush request makes the block busy
   `ISORT_ASSERT(a_flush_busy, (start && !busy && req_end_mark) |=> busy, "flush not started")

   // An insertion never stalls and gives no result
   `ISORT_ASSERT(a_insert_quiet, (start && !busy && !req_end_mark) |=> (!busy && !rsp_valid),
                 "insertion produced busy or a result")

   // Nothing follows the last result of a run
   `ISORT_ASSERT(a_last_ends, (rsp_valid && rsp_last_of_run) |=> !rsp_valid,
                 "result after the last of a run")

   // Reset clears busy and any result
   `ISORT_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!busy && !rsp_valid), "activity after reset")

endmodule

bind insertion_sorter isort_checker u_isort_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .req_data_value   (req_data_value),
   .req_end_mark     (req_end_mark),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last_of_run  (rsp_last_of_run),
   .rsp_overflowed   (rsp_overflowed)
);

// ===== test/sort_checker.sv =====
// Checker for the insertion sorter: predicts the sorted flush and compares every result.
`timescale 1ns / 100ps

module sort_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic signed [isort_pkg::DATA_WIDTH-1:0] req_data_value,
   input  logic                                   req_end_mark,
   input  logic                                   rsp_valid,
   input  logic signed [isort_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   input  logic                                   rsp_last_of_run,
   input  logic                                   rsp_overflowed,
   output int                                     error_count,
   output int                                     results_due,
   output int                                     results_checked
);

   localparam int DEPTH = (isort_pkg::CAPACITY > 64) ? 64 : isort_pkg::CAPACITY;

   typedef struct packed {
      logic signed [isort_pkg::DATA_WIDTH-1:0] value;
      logic                                    last;
      logic                                    ovf;
   } sorted_item_type;

   // Predicted contents of the chain
   logic signed [isort_pkg::DATA_WIDTH-1:0] held_values [DEPTH];
   int              held_count;
   logic            drop_seen;
   sorted_item_type sorted_due [$];
   int              fail_tally;
   int              checked_tally;

   initial begin
      error_count     = 0;
      results_due     = 0;
      results_checked = 0;
      held_count      = 0;
      drop_seen       = 1'b0;
      fail_tally      = 0;
      checked_tally   = 0;
   end

   // New value goes after any equal values already held
   task automatic place_value(input logic signed [isort_pkg::DATA_WIDTH-1:0] v);
      int pos;
      pos = 0;
      while (pos < held_count && held_values[pos] <= v) pos++;
      for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
      held_values[pos] = v;
      held_count++;
   endtask

   // End of set: queue every held value in order, then clear for the next set
   task automatic flush_set();
      sorted_item_type item;
      for (int i = 0; i < held_count; i++) begin
         item.value = held_values[i];
         item.last  = (i == held_count - 1);
         item.ovf   = drop_seen;
         sorted_due.push_back(item);
      end
      held_count = 0;
      drop_seen  = 1'b0;
   endtask

   task automatic check_result();
      sorted_item_type want;
      if (sorted_due.size() == 0) begin
         $display("%0t: unexpected result: expected none, got value %0d last %b ovf %b",
                  $time, rsp_sorted_value, rsp_last_of_run, rsp_overflowed);
         fail_tally++;
      end else begin
         want = sorted_due.pop_front();
         checked_tally++;
         if (rsp_sorted_value !== want.value) begin
            $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                     $time, want.value, rsp_sorted_value);
            fail_tally++;
         end
         if (rsp_last_of_run !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %b, got %b",
                     $time, want.last, rsp_last_of_run);
            fail_tally++;
         end
         if (rsp_overflowed !== want.ovf) begin
            $display("%0t: overflowed mismatch: expected %b, got %b",
                     $time, want.ovf, rsp_overflowed);
            fail_tally++;
         end
      end
   endtask

   // Results first, so a flush accepted on the same edge queues behind them
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         drop_seen  = 1'b0;
         sorted_due.delete();
      end else begin
         if (rsp_valid) check_result();
         if (start && !busy) begin
            if (req_end_mark) flush_set();
            else if (held_count >= DEPTH) drop_seen = 1'b1;
            else place_value(req_data_value);
         end
      end
      error_count     <= fail_tally;
      results_due     <= sorted_due.size();
      results_checked <= checked_tally;
   end

endmodule

// ===== test/testbench.sv =====
// Top of the insertion sorter testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int CAP        = isort_pkg::CAPACITY;
   localparam int LIMIT      = 300000;
   localparam int PHASE_REQS = 134;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [isort_pkg::DATA_WIDTH-1:0] req_data_value = '0;
   logic req_end_mark = 1'b0;
   logic busy;
   logic rsp_valid;
   logic signed [isort_pkg::DATA_WIDTH-1:0] rsp_sorted_value;
   logic rsp_last_of_run;
   logic rsp_overflowed;

   int error_count;
   int results_due;
   int results_checked;
   int idle_pct;
   int requests_sent;
   int sets_ended;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   insertion_sorter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_data_value   (req_data_value),
      .req_end_mark     (req_end_mark),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_overflowed   (rsp_overflowed)
   );

   sort_checker sort_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_value   (req_data_value),
      .req_end_mark     (req_end_mark),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_overflowed   (rsp_overflowed),
      .error_count      (error_count),
      .results_due      (results_due),
      .results_checked  (results_checked)
   );

   // Mix of extremes, tight clusters for duplicates, and full-range values
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         1, 2:    return 32'($urandom_range(8)) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   // One request: optional idle gap, then hold start until the block takes it
   task automatic send_request(input logic signed [31:0] value, input logic mark);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_data_value <= value;
      req_end_mark   <= mark;
      do @(posedge clock); while (busy);
      requests_sent++;
      if (mark) sets_ended++;
   endtask

   // A set of n values with random content, closed by an end mark
   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) send_request(pick_value(), 1'b0);
      send_request($urandom, 1'b1);
   endtask

   // Run watchdog
   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int phase_base;
      int r;
      requests_sent = 0;
      sets_ended    = 0;
      idle_pct      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty set, extremes, duplicates, end mark with junk data
      send_request(32'sd1234, 1'b1);
      send_request(32'sd0, 1'b0);
      send_request(32'sh7FFFFFFF, 1'b0);
      send_request(32'sh80000000, 1'b0);
      send_request(-32'sd1, 1'b0);
      send_request(32'sd1, 1'b0);
      send_request(32'sd5, 1'b0);
      send_request(32'sd5, 1'b0);
      send_request(-32'sd5, 1'b0);
      send_request(32'sd5, 1'b0);
      send_request(32'sh80000000, 1'b0);
      send_request(32'sh7FFFFFFF, 1'b0);
      send_request(32'hFFFFFFFF, 1'b1);
      send_request(-32'sd7, 1'b0);
      send_request(32'sh55AA55AA, 1'b1);
      send_request(32'sd0, 1'b1);
      send_request(32'sh7FFFFFFF, 1'b0);
      send_request(32'sh7FFFFFFF, 1'b1);

      // Random sets under three sender idle mixes; each opens with an overflow
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct   = (phase == 0) ? 32 : (phase == 1) ? 47 : 0;
         phase_base = requests_sent;
         send_set(CAP + $urandom_range(1, 3));
         while (requests_sent - phase_base < PHASE_REQS) begin
            r = $urandom_range(99);
            if (r < 10) send_set(0);
            else if (r < 16) send_set(CAP - 2 + $urandom_range(4));
            else send_set($urandom_range(1, 12));
         end
      end
      start <= 1'b0;

      // Drain, then watch for stray results
      do @(posedge clock); while (results_due != 0 || busy);
      repeat (CAP + 8) @(posedge clock);

      $display("Sent %0d requests in %0d sets across three sender idle mixes,",
               requests_sent, sets_ended);
      $display("including overflowing and empty sets; %0d sorted results checked.",
               results_checked);
      if (error_count == 0 && results_due == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
